// ----- hw/rtl/pidc_pkg.sv -----
// Shared types and constants for the PID controller with deadzone and windup clamp.
`default_nettype none

package pidc_pkg;

  localparam int unsigned GainW    = 32;
  localparam int unsigned InW      = 16;
  localparam int unsigned ErrW     = 17;
  localparam int unsigned IntegW   = 18;
  localparam int unsigned DriveW   = 9;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned QuotW    = 60;
  localparam int unsigned SumW     = 62;
  localparam int unsigned MulSteps = 8;
  localparam int unsigned DivSteps = 30;

  localparam logic [GainW-1:0] PropGainRst  = 32'd131072;
  localparam logic [GainW-1:0] IntegGainRst = 32'd655;
  localparam logic [GainW-1:0] DerivGainRst = 32'd32768;
  localparam logic [InW-1:0]   DeadBandRst  = 16'd5;
  localparam logic [InW-1:0]   MsPerS       = 16'd1000;
  localparam logic [7:0]       DriveLimit   = 8'd255;
  localparam logic signed [34:0] IntegLimit = 35'sd100000;

  typedef enum logic [1:0] {
    CFG_PROP_GAIN  = 2'd0,
    CFG_INTEG_GAIN = 2'd1,
    CFG_DERIV_GAIN = 2'd2,
    CFG_DEAD_BAND  = 2'd3
  } cfg_idx_e;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHECK = 11'b000_0000_0010,
    S_MINT  = 11'b000_0000_0100,
    S_INTEG = 11'b000_0000_1000,
    S_MI    = 11'b000_0001_0000,
    S_DI    = 11'b000_0010_0000,
    S_MD    = 11'b000_0100_0000,
    S_DD    = 11'b000_1000_0000,
    S_MP    = 11'b001_0000_0000,
    S_PADD  = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/pid_with_deadzone_and_windup_clamp.sv -----
// Top level: PID controller with deadzone, windup clamp and digit-serial arithmetic.
// In the deadzone the output is loaded straight from the check state. Otherwise the
// work is four radix-16 multiplies and two radix-4 divides (one each fewer with zero
// elapsed time) on one shared multiplier and one shared divider.
// Throughput: one word in flight; the next word is taken once the result is registered.
// Reset: async active low; gains and deadband to defaults, integral and last error to zero.
`default_nettype none

module pid_with_deadzone_and_windup_clamp
  import pidc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [GainW-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [InW-1:0]    target_i,
  input  logic signed [InW-1:0]    measured_i,
  input  logic [InW-1:0]           elapsed_ms_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DriveW-1:0] drive_o,
  output logic                     brake_on_o,
  output logic signed [ErrW-1:0]   error_out_o
);

  state_e state_q, state_d;

  logic [GainW-1:0]         prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [InW-1:0]           dead_band_q;
  logic signed [IntegW-1:0] integ_q;
  logic signed [ErrW-1:0]   prev_q;

  logic signed [ErrW-1:0]   err_q;
  logic [InW-1:0]           ms_q;
  logic [GainW-1:0]         mul_a_q;
  logic [ProdW-1:0]         prod_q;
  logic [QuotW-1:0]         div_n_q;
  logic [InW-1:0]           div_r_q, div_d_q;
  logic [4:0]               cnt_q;
  logic                     term_neg_q;
  logic signed [SumW-1:0]   sum_q;

  logic                     out_valid_q;
  logic signed [DriveW-1:0] drive_q;
  logic                     brake_q;
  logic signed [ErrW-1:0]   err_out_q;

  function automatic logic signed [SumW-1:0] signed_term(input logic neg,
                                                         input logic [QuotW-1:0] mag);
    logic signed [SumW-1:0] m;
    m = $signed({2'b00, mag});
    return neg ? -m : m;
  endfunction

  // error magnitude and deadzone
  logic [ErrW-1:0] err_abs;
  logic [InW-1:0]  err_mag;
  logic            in_dead;
  assign err_abs = err_q[ErrW-1] ? ErrW'(-err_q) : ErrW'(err_q);
  assign err_mag = err_abs[InW-1:0];
  assign in_dead = err_mag <= dead_band_q;

  // radix-16 shift-add multiplier step
  logic [3:0]       mul_digit;
  logic [35:0]      mul_part;
  logic [ProdW-1:0] mul_next;
  logic             mul_done;
  assign mul_digit = prod_q[3:0];
  assign mul_part  = {4'b0, prod_q[63:32]} + 36'(mul_a_q) * 36'(mul_digit);
  assign mul_next  = {mul_part, prod_q[31:4]};
  assign mul_done  = cnt_q == 5'(MulSteps - 1);

  // radix-4 restoring divider step
  logic [17:0]      div_r2, div_d1, div_d2, div_d3, div_rem;
  logic [1:0]       div_q;
  logic [QuotW-1:0] div_next;
  logic             div_done;
  assign div_r2 = {div_r_q, div_n_q[QuotW-1 -: 2]};
  assign div_d1 = {2'b00, div_d_q};
  assign div_d2 = {1'b0, div_d_q, 1'b0};
  assign div_d3 = div_d1 + div_d2;
  always_comb begin
    if (div_r2 >= div_d3) begin
      div_q   = 2'd3;
      div_rem = div_r2 - div_d3;
    end else if (div_r2 >= div_d2) begin
      div_q   = 2'd2;
      div_rem = div_r2 - div_d2;
    end else if (div_r2 >= div_d1) begin
      div_q   = 2'd1;
      div_rem = div_r2 - div_d1;
    end else begin
      div_q   = 2'd0;
      div_rem = div_r2;
    end
  end
  assign div_next = {div_n_q[QuotW-3:0], div_q};
  assign div_done = cnt_q == 5'(DivSteps - 1);

  // integral update with clamp
  logic signed [34:0]       int_prod, acc_sum;
  logic signed [IntegW-1:0] acc_clamp;
  logic                     acc_neg;
  logic [IntegW-2:0]        acc_mag;
  assign int_prod = $signed({3'b000, prod_q[31:0]});
  assign acc_sum  = 35'(integ_q) + (err_q[ErrW-1] ? -int_prod : int_prod);
  always_comb begin
    if (acc_sum > IntegLimit) begin
      acc_clamp = IntegW'(IntegLimit);
    end else if (acc_sum < -IntegLimit) begin
      acc_clamp = IntegW'(-IntegLimit);
    end else begin
      acc_clamp = IntegW'(acc_sum);
    end
  end
  assign acc_neg = acc_clamp[IntegW-1];
  assign acc_mag = acc_neg ? (IntegW-1)'(-acc_clamp) : (IntegW-1)'(acc_clamp);

  // error difference times 1000
  logic signed [17:0] de;
  logic               de_neg;
  logic [17:0]        de_mag;
  logic [27:0]        de_k;
  assign de     = 18'(err_q) - 18'(prev_q);
  assign de_neg = de[17];
  assign de_mag = de_neg ? 18'(-de) : 18'(de);
  assign de_k   = (28'(de_mag) << 10) - (28'(de_mag) << 4) - (28'(de_mag) << 3);

  // final scaling and saturation
  logic [SumW-1:0]          sum_abs;
  logic [SumW-17:0]         sum_int;
  logic [7:0]               drv_mag;
  logic signed [DriveW-1:0] drive_d;
  assign sum_abs = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign sum_int = sum_abs[SumW-1:16];
  assign drv_mag = (|sum_int[SumW-17:8]) ? DriveLimit : sum_int[7:0];
  assign drive_d = sum_q[SumW-1] ? -$signed({1'b0, drv_mag}) : $signed({1'b0, drv_mag});

  logic out_free, out_load;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = out_free && ((state_q == S_CHECK && in_dead) || state_q == S_FIN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        if (!in_dead) begin
          state_d = S_MINT;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_MINT:  if (mul_done) state_d = S_INTEG;
      S_INTEG: state_d = S_MI;
      S_MI:    if (mul_done) state_d = S_DI;
      S_DI:    if (div_done) state_d = (ms_q != '0) ? S_MD : S_MP;
      S_MD:    if (mul_done) state_d = S_DD;
      S_DD:    if (div_done) state_d = S_MP;
      S_MP:    if (mul_done) state_d = S_PADD;
      S_PADD:  state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      prop_gain_q  <= PropGainRst;
      integ_gain_q <= IntegGainRst;
      deriv_gain_q <= DerivGainRst;
      dead_band_q  <= DeadBandRst;
      integ_q      <= '0;
      prev_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_MINT || state_q == S_MI || state_q == S_MD || state_q == S_MP) begin
        cnt_q <= mul_done ? '0 : cnt_q + 5'd1;
      end else if (state_q == S_DI || state_q == S_DD) begin
        cnt_q <= div_done ? '0 : cnt_q + 5'd1;
      end else begin
        cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_INTEG) integ_q <= acc_clamp;
      if (state_q == S_FIN) prev_q <= err_q;
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PROP_GAIN:  prop_gain_q  <= cfg_data_i;
          CFG_INTEG_GAIN: integ_gain_q <= cfg_data_i;
          CFG_DERIV_GAIN: deriv_gain_q <= cfg_data_i;
          CFG_DEAD_BAND:  dead_band_q  <= cfg_data_i[InW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          err_q <= ErrW'(target_i) - ErrW'(measured_i);
          ms_q  <= elapsed_ms_i;
        end
      end
      S_CHECK: begin
        sum_q   <= '0;
        mul_a_q <= GainW'(ms_q);
        prod_q  <= ProdW'(err_mag);
      end
      S_MINT, S_MP: prod_q <= mul_next;
      S_INTEG: begin
        mul_a_q    <= integ_gain_q;
        prod_q     <= ProdW'(acc_mag);
        term_neg_q <= acc_neg;
      end
      S_MI, S_MD: begin
        prod_q <= mul_next;
        if (mul_done) begin
          div_n_q <= mul_next[QuotW-1:0];
          div_r_q <= '0;
          div_d_q <= (state_q == S_MI) ? MsPerS : ms_q;
        end
      end
      S_DI: begin
        div_n_q <= div_next;
        div_r_q <= div_rem[InW-1:0];
        if (div_done) begin
          sum_q <= sum_q + signed_term(term_neg_q, div_next);
          if (ms_q != '0) begin
            mul_a_q    <= deriv_gain_q;
            prod_q     <= ProdW'(de_k);
            term_neg_q <= de_neg;
          end else begin
            mul_a_q <= prop_gain_q;
            prod_q  <= ProdW'(err_mag);
          end
        end
      end
      S_DD: begin
        div_n_q <= div_next;
        div_r_q <= div_rem[InW-1:0];
        if (div_done) begin
          sum_q   <= sum_q + signed_term(term_neg_q, div_next);
          mul_a_q <= prop_gain_q;
          prod_q  <= ProdW'(err_mag);
        end
      end
      S_PADD: sum_q <= sum_q + signed_term(err_q[ErrW-1], prod_q[QuotW-1:0]);
      default: ;
    endcase
    if (out_load) begin
      drive_q   <= (state_q == S_FIN) ? drive_d : '0;
      brake_q   <= state_q != S_FIN;
      err_out_q <= err_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign brake_on_o  = brake_q;
  assign error_out_o = err_out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pidc_checker.sv -----
// Port-level checker for the PID controller, bound to the top level.
`default_nettype none

module pidc_checker
  import pidc_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DriveW-1:0] drive_o,
  input logic                     brake_on_o,
  input logic signed [ErrW-1:0]   error_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o) && $stable(error_out_o))
    else $error("output word dropped or changed while stalled");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_o != {1'b1, {(DriveW-1){1'b0}}})
    else $error("drive outside saturation range");

  a_brake_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && brake_on_o |-> drive_o == '0)
    else $error("brake with nonzero drive");

  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in flight");

endmodule

bind pid_with_deadzone_and_windup_clamp pidc_checker u_pidc_checker (.*);

`default_nettype wire

// ----- sim/pid_with_deadzone_and_windup_clamp_test.sv -----
// Testbench for the PID controller: directed table, random samples, gain sweeps, prediction.
`timescale 1ns / 100ps

module pid_with_deadzone_and_windup_clamp_test;
  import pidc_pkg::*;

  localparam longint IntegClamp = 100000;
  localparam longint DriveClamp = 255;
  localparam longint MsPerSec   = 1000;
  localparam int     DrainGap   = 120;

  typedef struct packed {
    logic signed [15:0] target;
    logic signed [15:0] measured;
    logic [15:0]        elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic signed [8:0]  drive;
    logic               brake_on;
    logic signed [16:0] error_out;
  } result_t;

  typedef struct {
    int tgt;
    int meas;
    int ms;
    bit typed;
    int drive;
    bit brake;
    int err;
  } row_t;

  // typed rows: after reset, deadzone, full-scale extremes
  row_t directed_rows [16] = '{
    '{0, 0, 0, 1, 0, 1, 0},
    '{5, 0, 10, 1, 0, 1, 5},
    '{-5, 0, 10, 1, 0, 1, -5},
    '{0, 6, 0, 0, 0, 0, 0},
    '{6, 0, 0, 0, 0, 0, 0},
    '{32767, -32768, 65535, 1, 255, 0, 65535},
    '{-32768, 32767, 65535, 1, -255, 0, -65535},
    '{32767, 32767, 65535, 1, 0, 1, 0},
    '{-32768, -32768, 0, 1, 0, 1, 0},
    '{100, 0, 2000, 0, 0, 0, 0},
    '{100, 0, 2000, 0, 0, 0, 0},
    '{-100, 0, 1, 0, 0, 0, 0},
    '{20, 0, 10, 0, 0, 0, 0},
    '{20, 10, 65535, 0, 0, 0, 0},
    '{-6, 0, 1, 0, 0, 0, 0},
    '{0, -6, 3, 0, 0, 0, 0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [GainW-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic signed [15:0] target = '0;
  logic signed [15:0] measured = '0;
  logic [15:0]       elapsed_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [8:0] drive;
  logic              brake_on;
  logic signed [16:0] error_out;

  // controller copy
  logic [31:0] m_prop_gain;
  logic [31:0] m_integ_gain;
  logic [31:0] m_deriv_gain;
  logic [15:0] m_dead_band;
  longint      m_integral;
  longint      m_prev_err;

  result_t pending_results [$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_cycles = 0;

  pid_with_deadzone_and_windup_clamp dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .target_i     (target),
    .measured_i   (measured),
    .elapsed_ms_i (elapsed_ms),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .drive_o      (drive),
    .brake_on_o   (brake_on),
    .error_out_o  (error_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t predict_drive(sample_t s);
    longint  e, ms, mag, acc, p, i, d, sum;
    result_t r;
    e   = longint'(s.target) - longint'(s.measured);
    ms  = longint'(s.elapsed_ms);
    mag = (e < 0) ? -e : e;
    r.error_out = e[16:0];
    if (mag <= longint'(m_dead_band)) begin
      r.drive    = '0;
      r.brake_on = 1'b1;
    end else begin
      acc = m_integral + e * ms;
      if (acc > IntegClamp) acc = IntegClamp;
      if (acc < -IntegClamp) acc = -IntegClamp;
      m_integral = acc;
      p = longint'(m_prop_gain) * e;
      i = (longint'(m_integ_gain) * acc) / MsPerSec;
      d = 0;
      if (ms != 0) d = (longint'(m_deriv_gain) * ((e - m_prev_err) * MsPerSec)) / ms;
      m_prev_err = e;
      sum = (p + i + d) / 65536;
      if (sum > DriveClamp) sum = DriveClamp;
      if (sum < -DriveClamp) sum = -DriveClamp;
      r.drive    = sum[8:0];
      r.brake_on = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // called at a falling edge; returns at a falling edge with in_valid still high
  task automatic send_sample(sample_t s, bit typed, result_t typed_want);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    target     <= s.target;
    measured   <= s.measured;
    elapsed_ms <= s.elapsed_ms;
    do @(posedge clk); while (!in_ready);
    r = predict_drive(s);
    pending_results.push_back(typed ? typed_want : r);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PROP_GAIN:  m_prop_gain  = data;
      CFG_INTEG_GAIN: m_integ_gain = data;
      CFG_DERIV_GAIN: m_deriv_gain = data;
      CFG_DEAD_BAND:  m_dead_band  = data[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(logic [31:0] prop, logic [31:0] integ, logic [31:0] deriv,
                           logic [15:0] band);
    in_valid <= 1'b0;
    wait_drain();
    cfg_write(CFG_PROP_GAIN, prop);
    cfg_write(CFG_INTEG_GAIN, integ);
    cfg_write(CFG_DERIV_GAIN, deriv);
    cfg_write(CFG_DEAD_BAND, {16'd0, band});
    cfg_valid <= 1'b0;
  endtask

  task automatic configure_plausible();
    configure($urandom_range(0, 32'h0008_0000), $urandom_range(0, 32'h0001_0000),
              $urandom_range(0, 32'h0001_0000), 16'($urandom_range(0, 50)));
  endtask

  function automatic sample_t make_pair(int e, int ms);
    sample_t s;
    int lo, hi, m;
    lo = (e >= 0) ? -32768 : -32768 - e;
    hi = (e >= 0) ? 32767 - e : 32767;
    m  = lo + int'($urandom_range(hi - lo));
    s.measured   = 16'(m);
    s.target     = 16'(m + e);
    s.elapsed_ms = 16'(ms);
    return s;
  endfunction

  function automatic sample_t make_sample();
    sample_t s;
    int kind, span, e, ms;
    kind = $urandom_range(99);
    if (kind < 55) begin
      span = (m_dead_band > 2000) ? 2200 : int'(m_dead_band) + 200;
      e    = int'($urandom_range(2 * span)) - span;
      ms   = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 60);
      s    = make_pair(e, ms);
    end else if (kind < 75) begin
      s = sample_t'({$urandom, 16'($urandom)});
    end else if (kind < 90) begin
      case ($urandom_range(3))
        0: ms = 0;
        1: ms = 1;
        2: ms = 65535;
        default: ms = $urandom_range(1000, 65535);
      endcase
      e = int'($urandom_range(4000)) - 2000;
      s = make_pair(e, ms);
    end else begin
      e = int'(m_dead_band) + int'($urandom_range(1));
      if (e > 65535) e = 65535;
      if ($urandom_range(1) == 1) e = -e;
      s = make_pair(e, $urandom_range(0, 100));
    end
    return s;
  endfunction

  task automatic run_phase(int count, int idle_mode);
    case (idle_mode)
      1: begin send_idle_pct = 67; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 67; end
      3: begin send_idle_pct = 28; recv_stall_pct = 28; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
    repeat (count) send_sample(make_sample(), 1'b0, '0);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, drive", drive, 0);
      end else begin
        want = pending_results.pop_front();
        if (drive !== want.drive) report_mismatch("drive", drive, want.drive);
        if (brake_on !== want.brake_on) report_mismatch("brake_on", brake_on, want.brake_on);
        if (error_out !== want.error_out) report_mismatch("error_out", error_out, want.error_out);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    sample_t s;
    result_t want;
    m_prop_gain  = PropGainRst;
    m_integ_gain = IntegGainRst;
    m_deriv_gain = DerivGainRst;
    m_dead_band  = DeadBandRst;
    m_integral   = 0;
    m_prev_err   = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    foreach (directed_rows[k]) begin
      s.target         = 16'(directed_rows[k].tgt);
      s.measured       = 16'(directed_rows[k].meas);
      s.elapsed_ms     = 16'(directed_rows[k].ms);
      want.drive       = 9'(directed_rows[k].drive);
      want.brake_on    = directed_rows[k].brake;
      want.error_out   = 17'(directed_rows[k].err);
      send_sample(s, directed_rows[k].typed, want);
    end

    run_phase(180, 1);
    configure_plausible();
    run_phase(200, 2);
    configure(32'd0, 32'd0, 32'd0, 16'd0);
    run_phase(120, 3);
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    run_phase(60, 0);
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    run_phase(150, 1);

    configure_plausible();
    run_phase(50, 0);
    hold_cycles = 400;
    run_phase(10, 0);
    in_valid <= 1'b0;
    wait_drain();
    run_phase(150, 0);

    configure($urandom, $urandom, $urandom, 16'($urandom_range(0, 65535)));
    run_phase(200, 3);
    configure_plausible();
    run_phase(250, 2);
    configure_plausible();
    run_phase(250, 1);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainGap) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- pid_with_deadzone_and_windup_clamp.f -----
hw/rtl/pidc_pkg.sv
hw/rtl/pid_with_deadzone_and_windup_clamp.sv
hw/rtl/pidc_checker.sv
sim/pid_with_deadzone_and_windup_clamp_test.sv
